FILE: rtl/core/mtv_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and controller/datapath interface types.
package mtv_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int AREA_BITS      = 24;
  localparam int CNT_BITS       = 8;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 24;

  localparam logic [AREA_BITS-1:0] AREA_LOW_RST    = 24'd1536;
  localparam logic [AREA_BITS-1:0] AREA_HIGH_RST   = 24'd230400;
  localparam logic [CNT_BITS-1:0]  THRESHOLD_RST   = 8'd1;
  localparam logic                 MOTION_ONLY_RST = 1'b0;
  localparam logic [CNT_BITS-1:0]  CNT_MAX         = 8'hFF;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_AREA_LOW    = 2'd0,
    REG_AREA_HIGH   = 2'd1,
    REG_THRESHOLD   = 2'd2,
    REG_MOTION_ONLY = 2'd3
  } cfg_reg_t;

  // Datapath step issued by the controller in each cycle.
  typedef enum logic [3:0] {
    STEP_NONE   = 4'd0,
    STEP_AREA   = 4'd1,
    STEP_WW     = 4'd2,
    STEP_HH     = 4'd3,
    STEP_DX     = 4'd4,
    STEP_DY     = 4'd5,
    STEP_SUM    = 4'd6,
    STEP_DIV    = 4'd7,
    STEP_LIM    = 4'd8,
    STEP_SQ     = 4'd9,
    STEP_COMMIT = 4'd10
  } step_t;

  typedef struct packed {
    logic  load;
    step_t step;
  } dp_cmd_t;

  typedef struct packed {
    logic root_done;
  } dp_status_t;

endpackage

FILE: rtl/core/mtv_isqrt.sv
`timescale 1ns / 1ps
// Bit-serial integer square root, one result bit per cycle.
module mtv_isqrt #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2*W-1:0] radicand,
  output logic [W-1:0]   root,
  output logic           done
);

  localparam int CW = $clog2(W);

  logic [2*W-1:0] rad;
  logic [W:0]     rem;
  logic [W-1:0]   root_r;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [W+2:0]   rem_t;
  logic [W+2:0]   trial;
  logic [W+2:0]   diff;
  logic           fits;

  always_comb begin
    rem_t = {rem, rad[2*W-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
    diff  = rem_t - trial;
    fits  = (rem_t >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      done   <= 1'b0;
      rad    <= radicand;
      rem    <= '0;
      root_r <= '0;
      cnt    <= '0;
    end else if (busy) begin
      rad    <= rad << 2;
      rem    <= fits ? diff[W:0] : rem_t[W:0];
      root_r <= {root_r[W-2:0], fits};
      cnt    <= cnt + 1'b1;
      if (cnt == CW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign root = root_r;

endmodule

FILE: rtl/core/mtv_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration, tracking state, shared multiplier, root unit and result register.
module mtv_datapath #(
  parameter int COORD_BITS = mtv_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_en,
  input  logic [mtv_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mtv_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                             op,
  input  logic [COORD_BITS-1:0]            box_x,
  input  logic [COORD_BITS-1:0]            box_y,
  input  logic [COORD_BITS:0]              box_w,
  input  logic [COORD_BITS:0]              box_h,
  input  mtv_pkg::dp_cmd_t                 cmd,
  output mtv_pkg::dp_status_t              status,
  output logic                             detected,
  output logic                             captured,
  output logic signed [COORD_BITS+1:0]     direction_x
);

  localparam int SW  = COORD_BITS + 1;
  localparam int RW  = COORD_BITS + 4;
  localparam int PW  = 2 * RW;
  localparam int SQW = 2 * COORD_BITS + 3;
  localparam int DW  = COORD_BITS + 2;
  localparam int AB  = mtv_pkg::AREA_BITS;
  localparam int CB  = mtv_pkg::CNT_BITS;
  // floor(v/3) == (v * RECIP) >> (RW+1) for every v below 2**RW.
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << (RW + 1)) + 64'd2) / 64'd3);

  // Configuration.
  logic [AB-1:0] area_low;
  logic [AB-1:0] area_high;
  logic [CB-1:0] threshold;
  logic          motion_only;

  // Current request.
  logic          op_r;
  logic [SW-1:0] w_r;
  logic [SW-1:0] h_r;
  logic [SW-1:0] cx_r;
  logic [SW-1:0] cy_r;
  logic [SW-1:0] adx_r;
  logic [SW-1:0] ady_r;

  // Working registers.
  logic [PW-1:0]  p;
  logic [SQW-1:0] acc;
  logic [SQW-1:0] s;
  logic [AB-1:0]  area_r;
  logic           area_ok;
  logic           size_ok;
  logic [RW-2:0]  lim;

  // Tracking state.
  logic [AB-1:0]          prev_area;
  logic [SW-1:0]          prev_cx;
  logic [SW-1:0]          prev_cy;
  logic [SW-1:0]          start_cx;
  logic                   idle;
  logic [CB-1:0]          count;
  logic                   was_detected;
  logic signed [DW-1:0]   motion_dx;
  logic                   lock_set;
  logic                   lock_positive;

  // Root unit.
  logic          root_start;
  logic [PW-1:0] root_in;
  logic [RW-1:0] root_out;
  logic          root_done;

  // Combinational helpers.
  logic [SW:0]   dx_full;
  logic [SW:0]   dy_full;
  logic [SW:0]   dx_neg;
  logic [SW:0]   dy_neg;
  logic [SW-1:0] adx;
  logic [SW-1:0] ady;
  logic [RW-1:0] ma;
  logic [RW-1:0] mb;
  logic [AB-1:0] size_diff;
  logic [DW-1:0] mdx;
  logic          mdx_pos;
  logic          mdx_neg;
  logic [CB-1:0] cnt_inc;
  logic          pos_ok;

  // Commit decisions.
  logic                 verdict;
  logic                 idle_next;
  logic [CB-1:0]        count_next;
  logic signed [DW-1:0] dx_next;
  logic                 lock_set_next;
  logic                 lock_pos_next;
  logic                 take_ref;
  logic                 take_start;

  mtv_isqrt #(
    .W(RW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (root_in),
    .root     (root_out),
    .done     (root_done)
  );

  assign status.root_done = root_done;
  assign root_start = (cmd.step == mtv_pkg::STEP_SUM);
  assign root_in    = (PW'(acc) << 4) + (PW'(acc) << 3) + PW'(acc);

  always_comb begin
    dx_full = {1'b0, cx_r} - {1'b0, prev_cx};
    dy_full = {1'b0, cy_r} - {1'b0, prev_cy};
    dx_neg  = -dx_full;
    dy_neg  = -dy_full;
    adx     = dx_full[SW] ? dx_neg[SW-1:0] : dx_full[SW-1:0];
    ady     = dy_full[SW] ? dy_neg[SW-1:0] : dy_full[SW-1:0];

    size_diff = (area_r >= prev_area) ? (area_r - prev_area) : (prev_area - area_r);

    mdx     = {1'b0, cx_r} - {1'b0, start_cx};
    mdx_neg = mdx[DW-1];
    mdx_pos = !mdx[DW-1] && (mdx != '0);
    cnt_inc = (count == mtv_pkg::CNT_MAX) ? count : count + 1'b1;
    pos_ok  = (s != '0) && (PW'(s) < p);
  end

  always_comb begin
    case (cmd.step)
      mtv_pkg::STEP_AREA: begin
        ma = RW'(w_r);
        mb = RW'(h_r);
      end
      mtv_pkg::STEP_WW: begin
        ma = RW'(w_r);
        mb = RW'(w_r);
      end
      mtv_pkg::STEP_HH: begin
        ma = RW'(h_r);
        mb = RW'(h_r);
      end
      mtv_pkg::STEP_DX: begin
        ma = RW'(adx_r);
        mb = RW'(adx_r);
      end
      mtv_pkg::STEP_DY: begin
        ma = RW'(ady_r);
        mb = RW'(ady_r);
      end
      mtv_pkg::STEP_DIV: begin
        ma = root_out;
        mb = RECIP;
      end
      mtv_pkg::STEP_SQ: begin
        ma = RW'(lim);
        mb = RW'(lim);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Outcome of a request, applied on the commit step.
  always_comb begin
    verdict       = was_detected;
    idle_next     = idle;
    count_next    = count;
    dx_next       = motion_dx;
    lock_set_next = lock_set;
    lock_pos_next = lock_positive;
    take_ref      = 1'b0;
    take_start    = 1'b0;
    if (op_r == mtv_pkg::OP_CLEAR) begin
      lock_set_next = 1'b0;
    end else begin
      verdict = 1'b0;
      if (area_ok) begin
        take_ref = 1'b1;
        if (idle) begin
          // First box in range becomes the reference.
          take_start = 1'b1;
          idle_next  = 1'b0;
          count_next = '0;
        end else if (size_ok && pos_ok) begin
          count_next = cnt_inc;
          if (cnt_inc >= threshold) begin
            if (was_detected) begin
              verdict = 1'b1;
            end else if (lock_set && ((mdx_pos && !lock_positive) ||
                                      (mdx_neg && lock_positive))) begin
              dx_next = '0;
            end else begin
              verdict = 1'b1;
              dx_next = signed'(mdx);
              if (!lock_set) begin
                lock_set_next = 1'b1;
                lock_pos_next = !mdx[DW-1];
              end
            end
          end
        end else begin
          idle_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_low    <= mtv_pkg::AREA_LOW_RST;
      area_high   <= mtv_pkg::AREA_HIGH_RST;
      threshold   <= mtv_pkg::THRESHOLD_RST;
      motion_only <= mtv_pkg::MOTION_ONLY_RST;
    end else if (cfg_en) begin
      case (mtv_pkg::cfg_reg_t'(cfg_index))
        mtv_pkg::REG_AREA_LOW:    area_low    <= cfg_data[AB-1:0];
        mtv_pkg::REG_AREA_HIGH:   area_high   <= cfg_data[AB-1:0];
        mtv_pkg::REG_THRESHOLD:   threshold   <= cfg_data[CB-1:0];
        mtv_pkg::REG_MOTION_ONLY: motion_only <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op;
      w_r  <= box_w;
      h_r  <= box_h;
      cx_r <= {1'b0, box_x} + {1'b0, box_w[SW-1:1]};
      cy_r <= {1'b0, box_y} + {1'b0, box_h[SW-1:1]};
    end
    case (cmd.step)
      mtv_pkg::STEP_AREA: begin
        p     <= ma * mb;
        adx_r <= adx;
        ady_r <= ady;
      end
      mtv_pkg::STEP_WW: begin
        area_ok <= (p >= PW'(area_low)) && (p <= PW'(area_high));
        area_r  <= p[AB-1:0];
        p       <= ma * mb;
      end
      mtv_pkg::STEP_HH: begin
        acc     <= p[SQW-1:0];
        size_ok <= (size_diff < (area_r >> 1));
        p       <= ma * mb;
      end
      mtv_pkg::STEP_DX: begin
        acc <= acc + p[SQW-1:0];
        p   <= ma * mb;
      end
      mtv_pkg::STEP_DY: begin
        s <= p[SQW-1:0];
        p <= ma * mb;
      end
      mtv_pkg::STEP_SUM: begin
        s <= s + p[SQW-1:0];
      end
      mtv_pkg::STEP_DIV: begin
        p <= ma * mb;
      end
      mtv_pkg::STEP_LIM: begin
        lim <= p[PW-1:RW+1];
      end
      mtv_pkg::STEP_SQ: begin
        p <= ma * mb;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_area     <= '0;
      prev_cx       <= '0;
      prev_cy       <= '0;
      start_cx      <= '0;
      idle          <= 1'b1;
      count         <= '0;
      was_detected  <= 1'b0;
      motion_dx     <= '0;
      lock_set      <= 1'b0;
      lock_positive <= 1'b0;
    end else if (cmd.step == mtv_pkg::STEP_COMMIT) begin
      was_detected  <= verdict;
      idle          <= idle_next;
      count         <= count_next;
      motion_dx     <= dx_next;
      lock_set      <= lock_set_next;
      lock_positive <= lock_pos_next;
      if (take_ref) begin
        prev_area <= area_r;
        prev_cx   <= cx_r;
        prev_cy   <= cy_r;
      end
      if (take_start) begin
        start_cx <= cx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == mtv_pkg::STEP_COMMIT) begin
      detected    <= verdict;
      captured    <= verdict && !motion_only;
      direction_x <= dx_next;
    end
  end

endmodule

FILE: rtl/core/mtv_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the datapath steps and runs both handshakes.
module mtv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  mtv_pkg::dp_status_t status,
  output mtv_pkg::dp_cmd_t    cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_AREA   = 12'b000000000010,
    S_WW     = 12'b000000000100,
    S_HH     = 12'b000000001000,
    S_DX     = 12'b000000010000,
    S_DY     = 12'b000000100000,
    S_SUM    = 12'b000001000000,
    S_ROOT   = 12'b000010000000,
    S_DIV    = 12'b000100000000,
    S_LIM    = 12'b001000000000,
    S_SQ     = 12'b010000000000,
    S_COMMIT = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   commit;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == S_COMMIT) && out_free;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.step   = mtv_pkg::STEP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_AREA;
        end
      end
      S_AREA: begin
        cmd.step   = mtv_pkg::STEP_AREA;
        state_next = S_WW;
      end
      S_WW: begin
        cmd.step   = mtv_pkg::STEP_WW;
        state_next = S_HH;
      end
      S_HH: begin
        cmd.step   = mtv_pkg::STEP_HH;
        state_next = S_DX;
      end
      S_DX: begin
        cmd.step   = mtv_pkg::STEP_DX;
        state_next = S_DY;
      end
      S_DY: begin
        cmd.step   = mtv_pkg::STEP_DY;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.step   = mtv_pkg::STEP_SUM;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        if (status.root_done) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step   = mtv_pkg::STEP_DIV;
        state_next = S_LIM;
      end
      S_LIM: begin
        cmd.step   = mtv_pkg::STEP_LIM;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.step   = mtv_pkg::STEP_SQ;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // The result register must be empty or emptying before state is updated.
        if (out_free) begin
          cmd.step   = mtv_pkg::STEP_COMMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/motion_track_validator.sv
`timescale 1ns / 1ps
// Top level of the motion track validator: controller plus datapath.
//
// Each request is one frame's bounding box or a clear of the direction lock, and each gives
// exactly one result. Every request, whatever the op, runs the same sequence of steps from
// acceptance until its result is loaded into the output register: a bit-serial square root
// of 25*(w*w+h*h), and single steps of one shared multiplier (area, squares, divide by three,
// square of the position limit). One request is in flight at a time; a new one is accepted
// as soon as the previous result sits in the output register, and a stalled result only holds
// off the final update of the next request. Configuration writes are taken at any time but
// are meant for while the block is idle.
module motion_track_validator #(
  parameter int COORD_BITS = mtv_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_en,
  input  logic [mtv_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mtv_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [COORD_BITS-1:0]             box_x,
  input  logic [COORD_BITS-1:0]             box_y,
  input  logic [COORD_BITS:0]               box_w,
  input  logic [COORD_BITS:0]               box_h,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              detected,
  output logic                              captured,
  output logic signed [COORD_BITS+1:0]      direction_x
);

  mtv_pkg::dp_cmd_t    cmd;
  mtv_pkg::dp_status_t status;

  mtv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mtv_datapath #(
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_en      (cfg_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .op          (op),
    .box_x       (box_x),
    .box_y       (box_y),
    .box_w       (box_w),
    .box_h       (box_h),
    .cmd         (cmd),
    .status      (status),
    .detected    (detected),
    .captured    (captured),
    .direction_x (direction_x)
  );

endmodule
